[src/llsf_pkg.sv]
// Shared constants, types and helpers for the least-squares line fit.
package llsf_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int FRAC_BITS   = 12;
  localparam int SAMPLE_W    = 24;
  localparam int N_W         = $clog2(MAX_SAMPLES) + 1;
  localparam int SUM_W       = SAMPLE_W + N_W - 1;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int SQ_W        = PROD_W + N_W - 1;
  localparam int OUT_W       = 48;
  localparam int R2_W        = 31;
  localparam int WIDE_W      = 176;
  localparam int MUL_B_W     = 72;
  localparam int CNT_W       = $clog2(WIDE_W + 1);
  localparam int QDEPTH      = 2;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic [N_W-1:0]          n;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SQ_W-1:0]  sxy;
    logic signed [SQ_W-1:0]  sxx;
    logic [SQ_W-1:0]         syy;
    logic                    dropped;
  } fit_rec_t;

  typedef enum logic {
    AR_MUL,
    AR_DIV
  } arith_op_t;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_RUN,
    AS_FIN
  } arith_state_t;

  typedef enum logic [4:0] {
    BS_IDLE,
    BS_M_NSXY,
    BS_M_SXSY,
    BS_M_NSXX,
    BS_M_SXSX,
    BS_CHECK,
    BS_D_SLOPE,
    BS_M_SYD,
    BS_M_NSX,
    BS_M_ND,
    BS_D_ICPT,
    BS_M_NSYY,
    BS_M_SYSY,
    BS_CHECK_T,
    BS_M_NN,
    BS_M_DT,
    BS_D_R2,
    BS_OUT
  } back_state_t;

  localparam wide_t SAT_MAX = {{(WIDE_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam wide_t SAT_MIN = {{(WIDE_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
  localparam wide_t R2_ONE  = wide_t'(64'd1 << (R2_W - 1));

  function automatic wide_t abs_wide(input wide_t v);
    abs_wide = v[WIDE_W-1] ? -v : v;
  endfunction

  function automatic logic [OUT_W-1:0] sat48(input wide_t v);
    logic [OUT_W-1:0] r;
    if (v > SAT_MAX) r = SAT_MAX[OUT_W-1:0];
    else if (v < SAT_MIN) r = SAT_MIN[OUT_W-1:0];
    else r = v[OUT_W-1:0];
    sat48 = r;
  endfunction

endpackage

[src/llsf_front.sv]
// Sample intake: counts, drops over capacity, accumulates the running sums.
module llsf_front import llsf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] x_value,
  input  logic signed [SAMPLE_W-1:0] y_value,
  input  logic                       last_sample,
  input  logic [QCNT_W-1:0]          q_count,
  output logic                       push,
  output fit_rec_t                   push_rec
);

  logic [N_W-1:0]            pair_count;
  logic                      dropped_flag;
  logic                      s1_valid;
  logic                      s1_add;
  logic                      s1_last;
  logic [N_W-1:0]            s1_n;
  logic                      s1_drop;
  logic signed [SAMPLE_W-1:0] s1_x;
  logic signed [SAMPLE_W-1:0] s1_y;
  logic signed [PROD_W-1:0]  s1_xy;
  logic signed [PROD_W-1:0]  s1_xx;
  logic signed [PROD_W-1:0]  s1_yy;
  logic signed [SUM_W-1:0]   acc_x, acc_x_next;
  logic signed [SUM_W-1:0]   acc_y, acc_y_next;
  logic signed [SQ_W-1:0]    acc_xy, acc_xy_next;
  logic signed [SQ_W-1:0]    acc_xx, acc_xx_next;
  logic [SQ_W-1:0]           acc_yy, acc_yy_next;
  logic                      accept;
  logic                      room;

  assign busy   = ({1'b0, q_count} + (QCNT_W+1)'(s1_valid & s1_last)) >= (QCNT_W+1)'(QDEPTH);
  assign accept = start & ~busy;
  assign room   = pair_count < N_W'(MAX_SAMPLES);

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count   <= '0;
      dropped_flag <= 1'b0;
      s1_valid     <= 1'b0;
      s1_last      <= 1'b0;
      s1_add       <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_last  <= accept & last_sample;
      s1_add   <= accept & room;
      if (accept) begin
        if (last_sample) begin
          pair_count   <= '0;
          dropped_flag <= 1'b0;
        end else begin
          if (room) pair_count <= pair_count + 1'b1;
          else dropped_flag <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_x  <= x_value;
    s1_y  <= y_value;
    s1_xy <= PROD_W'(x_value) * PROD_W'(y_value);
    s1_xx <= PROD_W'(x_value) * PROD_W'(x_value);
    s1_yy <= PROD_W'(y_value) * PROD_W'(y_value);
    s1_n  <= room ? pair_count + 1'b1 : pair_count;
    s1_drop <= dropped_flag | ~room;
  end

  always_comb begin
    acc_x_next  = acc_x;
    acc_y_next  = acc_y;
    acc_xy_next = acc_xy;
    acc_xx_next = acc_xx;
    acc_yy_next = acc_yy;
    if (s1_add) begin
      acc_x_next  = acc_x + SUM_W'(s1_x);
      acc_y_next  = acc_y + SUM_W'(s1_y);
      acc_xy_next = acc_xy + SQ_W'(s1_xy);
      acc_xx_next = acc_xx + SQ_W'(s1_xx);
      acc_yy_next = acc_yy + SQ_W'(s1_yy);
    end
    push              = s1_last;
    push_rec.n        = s1_n;
    push_rec.sx       = acc_x_next;
    push_rec.sy       = acc_y_next;
    push_rec.sxy      = acc_xy_next;
    push_rec.sxx      = acc_xx_next;
    push_rec.syy      = acc_yy_next;
    push_rec.dropped  = s1_drop;
  end

  always_ff @(posedge clk) begin
    if (rst || s1_last) begin
      acc_x  <= '0;
      acc_y  <= '0;
      acc_xy <= '0;
      acc_xx <= '0;
      acc_yy <= '0;
    end else begin
      acc_x  <= acc_x_next;
      acc_y  <= acc_y_next;
      acc_xy <= acc_xy_next;
      acc_xx <= acc_xx_next;
      acc_yy <= acc_yy_next;
    end
  end

endmodule

[src/llsf_queue.sv]
// Two-entry queue of finished sums between intake and solver.
module llsf_queue import llsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fit_rec_t          push_rec,
  input  logic              pop,
  output logic              not_empty,
  output fit_rec_t          head,
  output logic [QCNT_W-1:0] count
);

  fit_rec_t entries [QDEPTH];
  logic     wr_ptr;
  logic     rd_ptr;

  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

[src/llsf_arith.sv]
// Shared iterative unit: shift-add multiply and rounded restoring divide.
module llsf_arith import llsf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  arith_op_t op,
  input  wide_t     a,
  input  wide_t     b,
  output logic      done,
  output wide_t     result
);

  arith_state_t       state;
  arith_op_t          op_r;
  logic [WIDE_W-1:0]  ra;
  logic [WIDE_W-1:0]  rb;
  logic [WIDE_W:0]    acc;
  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic [WIDE_W:0]    rem_sh;
  logic [WIDE_W-1:0]  mag;

  assign rem_sh = {acc[WIDE_W-1:0], ra[WIDE_W-1]};
  assign mag    = (op_r == AR_MUL) ? acc[WIDE_W-1:0] : ra;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AS_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        AS_IDLE: begin
          if (start) begin
            op_r  <= op;
            acc   <= '0;
            state <= AS_RUN;
            if (op == AR_MUL) begin
              ra  <= abs_wide(a);
              rb  <= abs_wide(b);
              neg <= a[WIDE_W-1] ^ b[WIDE_W-1];
              cnt <= CNT_W'(MUL_B_W);
            end else begin
              ra  <= (abs_wide(a) << 1) + b;
              rb  <= b << 1;
              neg <= a[WIDE_W-1];
              cnt <= CNT_W'(WIDE_W);
            end
          end
        end
        AS_RUN: begin
          if (op_r == AR_MUL) begin
            if (rb[0]) acc <= {1'b0, acc[WIDE_W-1:0] + ra};
            ra <= ra << 1;
            rb <= rb >> 1;
          end else begin
            if (rem_sh >= {1'b0, rb}) begin
              acc <= rem_sh - {1'b0, rb};
              ra  <= {ra[WIDE_W-2:0], 1'b1};
            end else begin
              acc <= rem_sh;
              ra  <= {ra[WIDE_W-2:0], 1'b0};
            end
          end
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) state <= AS_FIN;
        end
        AS_FIN: begin
          result <= neg ? -mag : mag;
          done   <= 1'b1;
          state  <= AS_IDLE;
        end
        default: state <= AS_IDLE;
      endcase
    end
  end

endmodule

[src/llsf_back.sv]
// Solver sequencer: slope, intercept and R squared from one set of sums.
module llsf_back import llsf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_not_empty,
  input  fit_rec_t                 q_head,
  output logic                     pop,
  output logic                     done,
  output logic signed [OUT_W-1:0]  slope,
  output logic signed [OUT_W-1:0]  intercept,
  output logic [R2_W-1:0]          r2_value,
  output logic                     fit_valid,
  output logic                     sample_overflow,
  output logic [N_W-1:0]           samples_used
);

  back_state_t state, state_next;
  fit_rec_t    rec;
  wide_t       nn, dd, tt, tmp, tmp2;
  wide_t       w_n, w_sx, w_sy, w_sxy, w_sxx, w_syy;
  logic        issued;
  logic        ar_start;
  arith_op_t   ar_op;
  wide_t       ar_a, ar_b;
  logic        ar_done;
  wide_t       ar_res;
  logic        is_op;

  assign w_n   = wide_t'({1'b0, rec.n});
  assign w_sx  = wide_t'(rec.sx);
  assign w_sy  = wide_t'(rec.sy);
  assign w_sxy = wide_t'(rec.sxy);
  assign w_sxx = wide_t'(rec.sxx);
  assign w_syy = wide_t'({1'b0, rec.syy});

  llsf_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .start  (ar_start),
    .op     (ar_op),
    .a      (ar_a),
    .b      (ar_b),
    .done   (ar_done),
    .result (ar_res)
  );

  always_comb begin
    is_op      = 1'b1;
    ar_op      = AR_MUL;
    ar_a       = w_n;
    ar_b       = w_n;
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      BS_IDLE: begin
        is_op = 1'b0;
        if (q_not_empty) begin
          pop        = 1'b1;
          state_next = BS_M_NSXY;
        end
      end
      BS_M_NSXY: begin ar_a = w_n;  ar_b = w_sxy; end
      BS_M_SXSY: begin ar_a = w_sx; ar_b = w_sy;  end
      BS_M_NSXX: begin ar_a = w_n;  ar_b = w_sxx; end
      BS_M_SXSX: begin ar_a = w_sx; ar_b = w_sx;  end
      BS_CHECK: begin
        is_op = 1'b0;
        if (rec.n < N_W'(2) || dd == '0 || dd[WIDE_W-1]) state_next = BS_OUT;
        else state_next = BS_D_SLOPE;
      end
      BS_D_SLOPE: begin ar_op = AR_DIV; ar_a = nn << 16; ar_b = dd; end
      BS_M_SYD:   begin ar_a = dd; ar_b = w_sy; end
      BS_M_NSX:   begin ar_a = nn; ar_b = w_sx; end
      BS_M_ND:    begin ar_a = dd; ar_b = w_n;  end
      BS_D_ICPT:  begin ar_op = AR_DIV; ar_a = tmp << 16; ar_b = tmp2; end
      BS_M_NSYY:  begin ar_a = w_n;  ar_b = w_syy; end
      BS_M_SYSY:  begin ar_a = w_sy; ar_b = w_sy;  end
      BS_CHECK_T: begin
        is_op = 1'b0;
        if (tt == '0 || tt[WIDE_W-1]) state_next = BS_OUT;
        else state_next = BS_M_NN;
      end
      BS_M_NN:    begin ar_a = nn; ar_b = nn; end
      BS_M_DT:    begin ar_a = dd; ar_b = tt; end
      BS_D_R2:    begin ar_op = AR_DIV; ar_a = tmp << 30; ar_b = tmp2; end
      BS_OUT: begin
        is_op      = 1'b0;
        state_next = BS_IDLE;
      end
      default: begin
        is_op      = 1'b0;
        state_next = BS_IDLE;
      end
    endcase
    ar_start = is_op & ~issued;
    if (is_op && ar_done) state_next = back_state_t'(state + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BS_IDLE;
      issued <= 1'b0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == BS_OUT;
      if (ar_start) issued <= 1'b1;
      else if (ar_done) issued <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BS_IDLE && q_not_empty) begin
      rec             <= q_head;
      slope           <= '0;
      intercept       <= '0;
      r2_value        <= '0;
      fit_valid       <= 1'b0;
      sample_overflow <= q_head.dropped;
      samples_used    <= q_head.n;
    end
    if (state == BS_CHECK && state_next == BS_D_SLOPE) fit_valid <= 1'b1;
    if (ar_done) begin
      unique case (state)
        BS_M_NSXY:  tmp <= ar_res;
        BS_M_SXSY:  nn <= tmp - ar_res;
        BS_M_NSXX:  tmp <= ar_res;
        BS_M_SXSX:  dd <= tmp - ar_res;
        BS_D_SLOPE: slope <= sat48(ar_res);
        BS_M_SYD:   tmp <= ar_res;
        BS_M_NSX:   tmp <= tmp - ar_res;
        BS_M_ND:    tmp2 <= ar_res << FRAC_BITS;
        BS_D_ICPT:  intercept <= sat48(ar_res);
        BS_M_NSYY:  tmp <= ar_res;
        BS_M_SYSY:  tt <= tmp - ar_res;
        BS_M_NN:    tmp <= ar_res;
        BS_M_DT:    tmp2 <= ar_res;
        BS_D_R2: begin
          if (ar_res[WIDE_W-1]) r2_value <= '0;
          else if (ar_res > R2_ONE) r2_value <= R2_ONE[R2_W-1:0];
          else r2_value <= ar_res[R2_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

[src/linear_least_squares_fit_top.sv]
// Top level of the least-squares line fit with R squared.
// Pairs are taken one per cycle while busy is low; busy rises only when two
// finished data sets wait in or are entering the queue. On the pair marked
// last, one result follows on done, computed by the shared one-bit-per-cycle
// multiply and divide unit in eleven products and three quotients.
// A fit rejected for too few pairs or a zero denominator is done after four
// products; a zero total sum of squares ends after nine products and two
// quotients. Results cannot be held off by the receiver.
module linear_least_squares_fit_top import llsf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] x_value,
  input  logic signed [SAMPLE_W-1:0] y_value,
  input  logic                       last_sample,
  output logic                       done,
  output logic signed [OUT_W-1:0]    slope,
  output logic signed [OUT_W-1:0]    intercept,
  output logic [R2_W-1:0]            r2_value,
  output logic                       fit_valid,
  output logic                       sample_overflow,
  output logic [N_W-1:0]             samples_used
);

  logic              push;
  fit_rec_t          push_rec;
  logic              pop;
  logic              q_not_empty;
  fit_rec_t          q_head;
  logic [QCNT_W-1:0] q_count;

  llsf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .x_value     (x_value),
    .y_value     (y_value),
    .last_sample (last_sample),
    .q_count     (q_count),
    .push        (push),
    .push_rec    (push_rec)
  );

  llsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .count     (q_count)
  );

  llsf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .pop             (pop),
    .done            (done),
    .slope           (slope),
    .intercept       (intercept),
    .r2_value        (r2_value),
    .fit_valid       (fit_valid),
    .sample_overflow (sample_overflow),
    .samples_used    (samples_used)
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && !fit_valid |-> slope == '0 && intercept == '0 && r2_value == '0)
    else $error("rejected fit carries nonzero result");

  a_r2_range: assert property (@(posedge clk) disable iff (rst)
    done |-> r2_value <= R2_ONE[R2_W-1:0])
    else $error("r2_value above one");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    done && fit_valid |-> samples_used >= N_W'(2))
    else $error("valid fit from fewer than two samples");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH) && !(push && !pop && q_count == QCNT_W'(QDEPTH)))
    else $error("request queue overrun");

endmodule
